// File: sv/life_automaton_torus_assert.svh
// ---------------------------------------------------------------------------
// life_automaton_torus_assert.svh
// Assertion macros used by the checker of the life automaton.
// ---------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_TORUS_ASSERT_SVH
`define LIFE_AUTOMATON_TORUS_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LAT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lat_pkg.sv
// ---------------------------------------------------------------------------
// lat_pkg
// Grid sizes, operation codes, controller states and the command and status
// records that join the controller and the datapath.
// ---------------------------------------------------------------------------
package lat_pkg;

  localparam int GRID_W  = 64;
  localparam int GRID_H  = 64;
  localparam int XY_W    = 6;
  localparam int COL_AW  = $clog2(GRID_W);
  localparam int ROW_AW  = $clog2(GRID_H);
  // step counter runs to GRID_H + 2
  localparam int CNT_W   = $clog2(GRID_H + 3);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_WB,
    ST_RDONE,
    ST_NOP,
    ST_STEP
  } state_t;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_MERGE,
    WD_LIFE
  } wdata_sel_t;

  typedef struct packed {
    logic              capture;
    logic              rd_en;
    logic              rd_item_row;
    logic [ROW_AW-1:0] rd_row;
    logic              wr_cur;
    logic              wr_nxt;
    logic              wr_item_row;
    logic [ROW_AW-1:0] wr_row;
    wdata_sel_t        wsel;
    logic              shift;
    logic              swap;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    op_t op;
  } stat_t;

  // Wrap a coordinate onto the grid; a small constant table.
  function automatic logic [COL_AW-1:0] col_wrap(input logic [XY_W-1:0] v);
    logic [COL_AW-1:0] res;
    res = '0;
    for (int i = 0; i < (1 << XY_W); i++) begin
      if (v == XY_W'(i)) res = COL_AW'(i % GRID_W);
    end
    return res;
  endfunction

  function automatic logic [ROW_AW-1:0] row_wrap(input logic [XY_W-1:0] v);
    logic [ROW_AW-1:0] res;
    res = '0;
    for (int i = 0; i < (1 << XY_W); i++) begin
      if (v == XY_W'(i)) res = ROW_AW'(i % GRID_H);
    end
    return res;
  endfunction

endpackage

// File: sv/lat_ctrl.sv
// ---------------------------------------------------------------------------
// lat_ctrl
// Sequencer: clearing pass, cell write and read, generation sweep.
// ---------------------------------------------------------------------------
module lat_ctrl
  import lat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_op,
  input  stat_t      stat,
  output logic       busy,
  output cmd_t       cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             last_clear;
  logic             last_step;

  assign accept     = start && (state_r == ST_IDLE);
  assign last_clear = (cnt_r == CNT_W'(GRID_H - 1));
  assign last_step  = (cnt_r == CNT_W'(GRID_H + 2));
  assign busy       = (state_r != ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (last_clear) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_op))
            OP_WRITE, OP_READ: state_nxt = ST_FETCH;
            OP_STEP:           state_nxt = ST_STEP;
            default:           state_nxt = ST_NOP;
          endcase
        end
      end
      ST_FETCH: state_nxt = (stat.op == OP_WRITE) ? ST_WB : ST_RDONE;
      ST_WB:    state_nxt = ST_IDLE;
      ST_RDONE: state_nxt = ST_IDLE;
      ST_NOP:   state_nxt = ST_IDLE;
      ST_STEP:  if (last_step) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // row counter
  always_comb begin
    cnt_nxt = '0;
    if ((state_r == ST_CLEAR && !last_clear) || (state_r == ST_STEP && !last_step)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // commands
  always_comb begin
    cmd             = '0;
    cmd.wsel        = WD_ZERO;
    cmd.capture     = accept;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.wr_cur = 1'b1;
        cmd.wr_row = ROW_AW'(cnt_r);
        cmd.wsel   = WD_ZERO;
      end
      ST_FETCH: begin
        cmd.rd_en       = 1'b1;
        cmd.rd_item_row = 1'b1;
      end
      ST_WB: begin
        cmd.wr_cur      = 1'b1;
        cmd.wr_item_row = 1'b1;
        cmd.wsel        = WD_MERGE;
        cmd.finish      = 1'b1;
      end
      ST_RDONE, ST_NOP: cmd.finish = 1'b1;
      ST_STEP: begin
        // rows fetched: last, 0, 1, ..., last, 0
        cmd.rd_en = (cnt_r <= CNT_W'(GRID_H + 1));
        if (cnt_r == '0) begin
          cmd.rd_row = ROW_AW'(GRID_H - 1);
        end else if (cnt_r == CNT_W'(GRID_H + 1)) begin
          cmd.rd_row = '0;
        end else begin
          cmd.rd_row = ROW_AW'(cnt_r - CNT_W'(1));
        end
        cmd.shift  = (cnt_r >= CNT_W'(1));
        cmd.wr_nxt = (cnt_r >= CNT_W'(3));
        cmd.wr_row = ROW_AW'(cnt_r - CNT_W'(3));
        cmd.wsel   = WD_LIFE;
        cmd.swap   = last_step;
        cmd.finish = last_step;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: sv/lat_dpath.sv
// ---------------------------------------------------------------------------
// lat_dpath
// Two row-wide grid banks, the three-row window, the B3/S23 rule for a whole
// row and the result registers.
// ---------------------------------------------------------------------------
module lat_dpath
  import lat_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cmd_t            cmd,
  input  logic [1:0]      in_op,
  input  logic [XY_W-1:0] in_x,
  input  logic [XY_W-1:0] in_y,
  input  logic            in_value,
  output stat_t           stat,
  output logic            out_strobe,
  output logic            out_cell_value,
  output logic [1:0]      out_done_kind
);

  logic [GRID_W-1:0] mem0 [GRID_H];
  logic [GRID_W-1:0] mem1 [GRID_H];
  logic [GRID_W-1:0] rd0_r, rd1_r, rdata;
  logic [GRID_W-1:0] up_r, mid_r;
  logic [GRID_W-1:0] life_row, merged, wdata;
  logic              bank_r;
  op_t               op_r;
  logic [COL_AW-1:0] x_r;
  logic [ROW_AW-1:0] y_r;
  logic              value_r;
  logic [ROW_AW-1:0] rd_addr, wr_addr;
  logic              wr0, wr1;
  logic              strobe_r, cell_r;
  logic [1:0]        kind_r;

  assign stat.op = op_r;

  assign rd_addr = cmd.rd_item_row ? y_r : cmd.rd_row;
  assign wr_addr = cmd.wr_item_row ? y_r : cmd.wr_row;
  assign wr0     = (cmd.wr_cur && !bank_r) || (cmd.wr_nxt && bank_r);
  assign wr1     = (cmd.wr_cur && bank_r) || (cmd.wr_nxt && !bank_r);
  assign rdata   = bank_r ? rd1_r : rd0_r;

  // rule per column; window rows are up_r, mid_r and the fresh read
  for (genvar j = 0; j < GRID_W; j++) begin : g_col
    localparam int LF = (j + GRID_W - 1) % GRID_W;
    localparam int RT = (j + 1) % GRID_W;
    logic [3:0] n;
    assign n = 4'(up_r[LF]) + 4'(up_r[j]) + 4'(up_r[RT])
             + 4'(mid_r[LF]) + 4'(mid_r[RT])
             + 4'(rdata[LF]) + 4'(rdata[j]) + 4'(rdata[RT]);
    assign life_row[j] = (n == 4'd3) || (mid_r[j] && (n == 4'd2));
  end

  always_comb begin
    merged        = rdata;
    merged[x_r]   = value_r;
  end

  always_comb begin
    case (cmd.wsel)
      WD_MERGE: wdata = merged;
      WD_LIFE:  wdata = life_row;
      default:  wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr0) mem0[wr_addr] <= wdata;
    if (cmd.rd_en) rd0_r <= mem0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr1) mem1[wr_addr] <= wdata;
    if (cmd.rd_en) rd1_r <= mem1[rd_addr];
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op_t'(in_op);
      x_r     <= col_wrap(in_x);
      y_r     <= row_wrap(in_y);
      value_r <= in_value;
    end
    if (cmd.shift) begin
      up_r  <= mid_r;
      mid_r <= rdata;
    end
    if (cmd.finish) begin
      cell_r <= (op_r == OP_READ) ? rdata[x_r] : 1'b0;
      kind_r <= op_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.finish;
      if (cmd.swap) bank_r <= !bank_r;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_cell_value = cell_r;
  assign out_done_kind  = kind_r;

endmodule

// File: sv/life_automaton_torus.sv
// ---------------------------------------------------------------------------
// life_automaton_torus
// Conway B3/S23 life on a 64 by 64 torus, with cell write, cell read and a
// one-generation step, built as a controller and a row-wide datapath.
// ---------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  request   | start, busy        | in_op, in_x, in_y, in_value
//  result    | out_strobe (1 clk) | out_cell_value, out_done_kind
//
// A request is taken at a clock edge with start high and busy low; every
// request gives one result, one cycle wide, which the receiver cannot stall.
// Write and read: the cell's row is fetched, then written back with the cell
// merged in (write) or the cell is taken from it (read). Unused op: a no-op
// state only. Step: the sweep reads one row per cycle through the single row
// read port of the grid bank. After reset a clearing pass zeroes the current
// bank a row at a time; busy stays high throughout.
//
module life_automaton_torus
  import lat_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      in_op,
  input  logic [XY_W-1:0] in_x,
  input  logic [XY_W-1:0] in_y,
  input  logic            in_value,
  output logic            out_strobe,
  output logic            out_cell_value,
  output logic [1:0]      out_done_kind
);

  // command and status between the sequencer and the datapath
  cmd_t  cmd;
  stat_t stat;

  // Sequence the clearing pass, the read-modify-write of a cell, the read
  // and the generation sweep; hold busy high while any of them runs.
  lat_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold both banks; build the next generation a row at a time in the
  // spare bank and swap banks at the end of the sweep instead of copying.
  lat_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_op          (in_op),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_value       (in_value),
    .stat           (stat),
    .out_strobe     (out_strobe),
    .out_cell_value (out_cell_value),
    .out_done_kind  (out_done_kind)
  );

endmodule

// File: sv/lat_checker.sv
// ---------------------------------------------------------------------------
// lat_checker
// Port-level checks on the request and result timing of the automaton.
// ---------------------------------------------------------------------------
`include "life_automaton_torus_assert.svh"

module lat_checker
  import lat_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic [1:0]      in_op,
  input logic            out_strobe,
  input logic            out_cell_value,
  input logic [1:0]      out_done_kind
);

  `LAT_ASSERT_SAME(a_cell_only_on_read, clk, rst_n, out_strobe && (out_done_kind != OP_READ), !out_cell_value, "cell value set on a non-read result")
  `LAT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy, "busy low after a request")
  `LAT_ASSERT_SAME(a_idle_on_strobe, clk, rst_n, out_strobe, !busy, "busy high on a result")
  `LAT_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe, "result strobe wider than one cycle")
  `LAT_ASSERT_SAME(a_nop_latency, clk, rst_n, start && !busy && (in_op == OP_NONE), ##2 (out_strobe && (out_done_kind == OP_NONE)), "unused op result late")

endmodule

bind life_automaton_torus lat_checker u_lat_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_op          (in_op),
  .out_strobe     (out_strobe),
  .out_cell_value (out_cell_value),
  .out_done_kind  (out_done_kind)
);

// File: dv/life_automaton_torus_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// life_automaton_torus_test
// Self-checking bench for the toroidal life grid. It drives write, step, read
// and unused requests and keeps its own copy of the board. Every result strobe
// is checked in order against the outcome worked out when its request was
// taken. A short table of directed requests comes first, then patterns seeded
// at random places on the torus under several sender idling phases.
// ---------------------------------------------------------------------------
module life_automaton_torus_test;
  import lat_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000; // longer than a step or the longest sender gap
  localparam int SETTLE_CYCLES  = 80;   // longer than one step
  localparam int MAX_GAP        = 12;
  localparam int MAX_REPORTS    = 50;
  localparam int PHASE_ITEMS    = 22;

  // 3 by 3 seeds, bit index = row * 3 + column
  localparam logic [8:0] GLIDER_CELLS  = 9'h1E2;
  localparam logic [8:0] BLINKER_CELLS = 9'h038;
  localparam logic [8:0] BLOCK_CELLS   = 9'h01B;

  typedef struct packed {
    logic alive;
    op_t  kind;
  } outcome_t;

  typedef struct {
    op_t             op;
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic            v;
    bit              typed;
    outcome_t        want;
  } plan_row_t;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  logic [1:0]      in_op;
  logic [XY_W-1:0] in_x;
  logic [XY_W-1:0] in_y;
  logic            in_value;
  logic            out_strobe;
  logic            out_cell_value;
  logic [1:0]      out_done_kind;

  // Board as the block should hold it, and the scratch for a generation.
  bit board   [GRID_H][GRID_W];
  bit scratch [GRID_H][GRID_W];

  outcome_t pending_outcomes[$];
  int       fault_count;
  int       idle_cycles;
  int       idle_pct;
  int       sent_count;

  life_automaton_torus dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_cell_value (out_cell_value),
    .out_done_kind  (out_done_kind)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Build one generation of B3/S23 in the scratch, then replace the board.
  function automatic void advance_board();
    int n;
    for (int r = 0; r < GRID_H; r++) begin
      for (int c = 0; c < GRID_W; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0)
              n += board[(r + dr + GRID_H) % GRID_H][(c + dc + GRID_W) % GRID_W];
          end
        end
        scratch[r][c] = board[r][c] ? (n == 2 || n == 3) : (n == 3);
      end
    end
    board = scratch;
  endfunction

  // Apply one request to the board and return the result it must give.
  function automatic outcome_t apply_request(op_t op, logic [XY_W-1:0] x,
                                             logic [XY_W-1:0] y, logic v);
    outcome_t o;
    int cx;
    int cy;
    cx = int'(x) % GRID_W;
    cy = int'(y) % GRID_H;
    o.alive = 1'b0;
    o.kind  = op;
    case (op)
      OP_WRITE: board[cy][cx] = v;
      OP_STEP:  advance_board();
      OP_READ:  o.alive = board[cy][cx];
      default:  ;
    endcase
    return o;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // A typed outcome, where given, replaces the predicted one in the queue.
  task automatic issue_request(op_t op, logic [XY_W-1:0] x, logic [XY_W-1:0] y,
                               logic v, bit typed = 1'b0, outcome_t want = '0);
    outcome_t predicted;
    if ($urandom_range(99) < idle_pct) begin
      // hold start low for a while; never lowered and raised in one step
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
    end
    start    <= 1'b1;
    in_op    <= op;
    in_x     <= x;
    in_y     <= y;
    in_value <= v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predicted = apply_request(op, x, y, v);
    pending_outcomes.push_back(typed ? want : predicted);
    sent_count++;
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_drained();
    while (pending_outcomes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Seed a 3 by 3 pattern anywhere on the torus (at times across an edge), run it
  // for a few generations and read cells in and around it.
  task automatic seed_pattern();
    logic [XY_W-1:0] ox;
    logic [XY_W-1:0] oy;
    logic [8:0]      shape;
    ox = XY_W'($urandom_range(63));
    oy = XY_W'($urandom_range(63));
    case ($urandom_range(3))
      0:       shape = GLIDER_CELLS;
      1:       shape = BLINKER_CELLS;
      2:       shape = BLOCK_CELLS;
      default: shape = 9'($urandom_range(511));
    endcase
    // write every cell of the patch so that old debris is cleared
    for (int i = 0; i < 9; i++)
      issue_request(OP_WRITE, ox + XY_W'(i % 3), oy + XY_W'(i / 3), shape[i]);
    repeat ($urandom_range(1, 3))
      issue_request(OP_STEP, XY_W'($urandom), XY_W'($urandom), 1'($urandom));
    repeat (4)
      issue_request(OP_READ, ox + XY_W'($urandom_range(4)) - XY_W'(1),
                    oy + XY_W'($urandom_range(4)) - XY_W'(1), 1'($urandom));
  endtask

  // Check each strobe against the oldest outstanding outcome.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: result with none expected: expected none actual cell %0d kind %0d",
                   $time, out_cell_value, out_done_kind);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_cell_value !== want.alive) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("%0t: out_cell_value expected %0d actual %0d (kind %0d)",
                     $time, want.alive, out_cell_value, want.kind);
        end
        if (out_done_kind !== want.kind) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("%0t: out_done_kind expected %0d actual %0d",
                     $time, want.kind, out_done_kind);
        end
      end
    end
  end

  // Count cycles in which neither a request nor a result is taken.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe === 1'b1)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    plan_row_t plan[$];
    int        phase_end;
    int        pick;

    // Directed rows. Typed outcomes only where obvious: reads of a cleared
    // board, writes and the unused code; everything else goes to the predictor.
    plan = '{
      // cleared board after reset; value is ignored by a read
      '{OP_READ,  6'd0,  6'd0,  1'b1, 1'b1, '{1'b0, OP_READ}},
      '{OP_READ,  6'd63, 6'd63, 1'b0, 1'b1, '{1'b0, OP_READ}},
      // unused code: no state change, kind echoed
      '{OP_NONE,  6'd63, 6'd63, 1'b1, 1'b1, '{1'b0, OP_NONE}},
      // 2 by 2 block split over all four corners: still life across both wraps
      '{OP_WRITE, 6'd0,  6'd0,  1'b1, 1'b1, '{1'b0, OP_WRITE}},
      '{OP_WRITE, 6'd63, 6'd63, 1'b1, 1'b1, '{1'b0, OP_WRITE}},
      '{OP_WRITE, 6'd63, 6'd0,  1'b1, 1'b1, '{1'b0, OP_WRITE}},
      '{OP_WRITE, 6'd0,  6'd63, 1'b1, 1'b1, '{1'b0, OP_WRITE}},
      '{OP_READ,  6'd0,  6'd0,  1'b0, 1'b0, '{1'b0, OP_READ}},
      // step ignores its coordinates and value
      '{OP_STEP,  6'd42, 6'd17, 1'b1, 1'b0, '{1'b0, OP_STEP}},
      '{OP_READ,  6'd63, 6'd63, 1'b0, 1'b0, '{1'b0, OP_READ}},
      '{OP_READ,  6'd63, 6'd0,  1'b0, 1'b0, '{1'b0, OP_READ}},
      '{OP_READ,  6'd1,  6'd1,  1'b0, 1'b0, '{1'b0, OP_READ}},
      // horizontal blinker across the left/right seam
      '{OP_WRITE, 6'd62, 6'd32, 1'b1, 1'b1, '{1'b0, OP_WRITE}},
      '{OP_WRITE, 6'd63, 6'd32, 1'b1, 1'b1, '{1'b0, OP_WRITE}},
      '{OP_WRITE, 6'd0,  6'd32, 1'b1, 1'b1, '{1'b0, OP_WRITE}},
      '{OP_STEP,  6'd0,  6'd0,  1'b0, 1'b0, '{1'b0, OP_STEP}},
      '{OP_READ,  6'd63, 6'd31, 1'b0, 1'b0, '{1'b0, OP_READ}},
      '{OP_READ,  6'd63, 6'd33, 1'b0, 1'b0, '{1'b0, OP_READ}},
      '{OP_READ,  6'd62, 6'd32, 1'b0, 1'b0, '{1'b0, OP_READ}},
      // kill one corner of the block and let the rest react
      '{OP_WRITE, 6'd0,  6'd0,  1'b0, 1'b1, '{1'b0, OP_WRITE}},
      '{OP_STEP,  6'd63, 6'd63, 1'b1, 1'b0, '{1'b0, OP_STEP}},
      '{OP_READ,  6'd0,  6'd0,  1'b1, 1'b0, '{1'b0, OP_READ}},
      '{OP_READ,  6'd63, 6'd32, 1'b0, 1'b0, '{1'b0, OP_READ}},
      '{OP_NONE,  6'd0,  6'd0,  1'b0, 1'b1, '{1'b0, OP_NONE}},
      '{OP_READ,  6'd0,  6'd63, 1'b0, 1'b0, '{1'b0, OP_READ}}
    };

    // known values on every input from the start; board cleared as at reset
    rst_n       = 1'b0;
    start       = 1'b0;
    in_op       = OP_NONE;
    in_x        = '0;
    in_y        = '0;
    in_value    = 1'b0;
    fault_count = 0;
    idle_cycles = 0;
    idle_pct    = 0;
    sent_count  = 0;

    // hold reset low, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows back to back; the clearing pass after reset is absorbed
    // by waiting on busy
    foreach (plan[i])
      issue_request(plan[i].op, plan[i].x, plan[i].y, plan[i].v, plan[i].typed, plan[i].want);

    // pause the sender until the block has answered everything
    start <= 1'b0;
    wait_drained();

    // random phases: no idling, heavy idling, no idling, light idling
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 48 : (phase == 3) ? 15 : 0;
      phase_end = sent_count + PHASE_ITEMS;
      while (sent_count < phase_end) begin
        pick = $urandom_range(9);
        if (pick < 6)
          seed_pattern();
        else if (pick < 9)
          issue_request(op_t'($urandom_range(3)), XY_W'($urandom), XY_W'($urandom),
                        1'($urandom));
        else
          issue_request(OP_STEP, XY_W'($urandom), XY_W'($urandom), 1'($urandom));
      end
    end

    // drop the request line, drain, then give a trailing window for strays
    start <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fault_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
